// File: rtl/core/shfc_pkg.sv
`default_nettype none

package shfc_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_SYNC_BYTE_0   = 3'd0;
  localparam logic [2:0] REG_SYNC_BYTE_1   = 3'd1;
  localparam logic [2:0] REG_SYNC_BYTE_2   = 3'd2;
  localparam logic [2:0] REG_SYNC_BYTE_3   = 3'd3;
  localparam logic [2:0] REG_HEADER_LENGTH = 3'd4;
  localparam logic [2:0] REG_FRAME_LENGTH  = 3'd5;

  localparam logic [7:0] SYNC_BYTE_0_RST   = 8'hB5;
  localparam logic [7:0] SYNC_BYTE_1_RST   = 8'h62;
  localparam logic [7:0] SYNC_BYTE_2_RST   = 8'h01;
  localparam logic [7:0] SYNC_BYTE_3_RST   = 8'h07;
  localparam logic [2:0] HEADER_LENGTH_RST = 3'd4;
  localparam logic [7:0] FRAME_LENGTH_RST  = 8'd100;

  localparam int POS_LIMIT = 128;
  localparam logic [2:0] HEADER_MIN = 3'd1;
  localparam logic [2:0] HEADER_MAX = 3'd4;

  typedef struct packed {
    logic [3:0][7:0] sync_bytes;
    logic [2:0]      header_len;  // effective, 1..4
    logic [7:0]      frame_len;   // effective, header_len+1..cap
  } cfg_t;

  typedef struct packed {
    logic       accepted;
    logic [6:0] position;
    logic [7:0] data_byte;
    logic       frame_complete;
    logic       sync_lost;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/sync_header_frame_capture.sv
`default_nettype none

// Frame hunter for a received serial byte stream.
// Input channel in_valid/in_ready carries one rx_byte per beat. Every beat
// produces exactly one result beat on out_valid/out_ready with accepted,
// position, data_byte, frame_complete and sync_lost.
// The header is matched against up to four sync bytes; a mismatch while
// hunting drops the byte, a mismatch later in the header also flags
// sync_lost and restarts the hunt. After the header every byte is taken
// until frame_length bytes are in, and the last one flags frame_complete.
// Configuration: cfg_valid/cfg_ready with cfg_index (0-3 sync bytes,
// 4 header_length, 5 frame_length) and cfg_data; cfg_ready is always high.
// Write registers only while no result is pending.
// Each result is written into the result queue before it reaches the output.
// Throughput: one byte per cycle while the result queue has room, set by the position update.
// A two-beat result queue separates the sides: a stalled receiver lets the
// block take up to two more bytes before in_ready drops.
// Reset (rst, synchronous) restores the default sync bytes 0xB5 0x62 0x01
// 0x07, header_length 4, frame_length 100, and empties the queue.
module sync_header_frame_capture
  import shfc_pkg::*;
#(
  parameter int MAX_FRAME = 128
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            accepted,
  output logic [6:0]      position,
  output logic [7:0]      data_byte,
  output logic            frame_complete,
  output logic            sync_lost
);

  cfg_t    cfg;
  result_t front_result;
  result_t head;

  shfc_regs #(
    .MAX_FRAME(MAX_FRAME)
  ) u_regs (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  shfc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_valid(in_valid),
    .in_take (in_ready),
    .rx_byte (rx_byte),
    .result  (front_result)
  );

  shfc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (in_valid && in_ready),
    .push_data(front_result),
    .not_full (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head     (head)
  );

  assign accepted       = head.accepted;
  assign position       = head.position;
  assign data_byte      = head.data_byte;
  assign frame_complete = head.frame_complete;
  assign sync_lost      = head.sync_lost;

endmodule

`default_nettype wire

// File: rtl/core/shfc_regs.sv
`default_nettype none

module shfc_regs
  import shfc_pkg::*;
#(
  parameter int MAX_FRAME = 128
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  output cfg_t            cfg
);

  localparam int FRAME_CAP = (MAX_FRAME > POS_LIMIT) ? POS_LIMIT : MAX_FRAME;
  localparam logic [8:0] FRAME_CAP_V = 9'(FRAME_CAP);

  logic [3:0][7:0] sync_bytes;
  logic [2:0]      header_length;
  logic [7:0]      frame_length;

  logic [2:0] hl_eff;
  logic [3:0] fl_min;
  logic [7:0] fl_capped;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_bytes[0] <= SYNC_BYTE_0_RST;
      sync_bytes[1] <= SYNC_BYTE_1_RST;
      sync_bytes[2] <= SYNC_BYTE_2_RST;
      sync_bytes[3] <= SYNC_BYTE_3_RST;
      header_length <= HEADER_LENGTH_RST;
      frame_length  <= FRAME_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SYNC_BYTE_0:   sync_bytes[0] <= cfg_data;
        REG_SYNC_BYTE_1:   sync_bytes[1] <= cfg_data;
        REG_SYNC_BYTE_2:   sync_bytes[2] <= cfg_data;
        REG_SYNC_BYTE_3:   sync_bytes[3] <= cfg_data;
        REG_HEADER_LENGTH: header_length <= cfg_data[2:0];
        REG_FRAME_LENGTH:  frame_length <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (header_length < HEADER_MIN) hl_eff = HEADER_MIN;
    else if (header_length > HEADER_MAX)     hl_eff = HEADER_MAX;
    else                                     hl_eff = header_length;

    fl_min = {1'b0, hl_eff} + 4'd1;

    if ({1'b0, frame_length} > FRAME_CAP_V) fl_capped = FRAME_CAP_V[7:0];
    else                                    fl_capped = frame_length;

    cfg.sync_bytes = sync_bytes;
    cfg.header_len = hl_eff;
    if (fl_capped < {4'd0, fl_min}) cfg.frame_len = {4'd0, fl_min};
    else                            cfg.frame_len = fl_capped;
  end

endmodule

`default_nettype wire

// File: rtl/core/shfc_front.sv
`default_nettype none

module shfc_front
  import shfc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  cfg_t            cfg,
  input  wire logic       in_valid,
  input  wire logic       in_take,
  input  wire logic [7:0] rx_byte,
  output result_t         result
);

  logic [6:0] frame_position;
  logic [6:0] frame_position_next;
  logic       in_header;
  logic       match;
  logic [7:0] pos_plus;

  always_comb begin
    in_header = frame_position < {4'd0, cfg.header_len};
    match     = rx_byte == cfg.sync_bytes[frame_position[1:0]];
    pos_plus  = {1'b0, frame_position} + 8'd1;

    result              = '0;
    frame_position_next = frame_position;
    if (in_header) begin
      if (match) begin
        result.accepted     = 1'b1;
        frame_position_next = pos_plus[6:0];
      end else begin
        // mismatch past the first header byte drops sync
        result.sync_lost    = frame_position != 7'd0;
        frame_position_next = 7'd0;
      end
    end else begin
      result.accepted = 1'b1;
      if (pos_plus >= cfg.frame_len) begin
        result.frame_complete = 1'b1;
        frame_position_next   = 7'd0;
      end else begin
        frame_position_next = pos_plus[6:0];
      end
    end
    if (result.accepted) begin
      result.position  = frame_position;
      result.data_byte = rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= 7'd0;
    end else if (in_valid && in_take) begin
      frame_position <= frame_position_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/shfc_queue.sv
`default_nettype none

module shfc_queue
  import shfc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  result_t   push_data,
  output logic      not_full,
  output logic      out_valid,
  input  wire logic out_ready,
  output result_t   head
);

  result_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign not_full  = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign pop       = out_valid && out_ready;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire
